// ----- src/bcs_pkg.sv -----
// Shared types, constants and tables of the Bezier curve sampler.
package bcs_pkg;

	localparam int MAX_CONTROL = 8;
	localparam int MAX_SAMPLES = 32;
	localparam int COORD_W = 16;
	localparam int OUT_W = 24;
	localparam int IDX_W = 5;
	localparam int CNT_W = 4;
	localparam int PT_W = $clog2(MAX_CONTROL);
	localparam int DEN_W = 35;	// steps^n with steps <= 31 and n <= 7
	localparam int WPART_W = 41;	// partial weight products before a zero factor
	localparam int ACC_W = 51;	// weighted sum of 16-bit coordinates
	localparam int REM_W = 59;	// |acc| * 256 plus half the divisor
	localparam int FRAC_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_STEPS = 2'd1;

	localparam logic [5:0] BINOM [MAX_CONTROL][MAX_CONTROL] = '{
		'{6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
		'{6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
		'{6'd1, 6'd2, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
		'{6'd1, 6'd3, 6'd3, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0},
		'{6'd1, 6'd4, 6'd6, 6'd4, 6'd1, 6'd0, 6'd0, 6'd0},
		'{6'd1, 6'd5, 6'd10, 6'd10, 6'd5, 6'd1, 6'd0, 6'd0},
		'{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6, 6'd1, 6'd0},
		'{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
	};

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_DEN,
		ST_SAMPLE,
		ST_TERM,
		ST_WMUL,
		ST_PROD,
		ST_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic            store_we;
		logic [PT_W-1:0] store_idx;
		logic            curve_start;
		logic            den_mul;
		logic            acc_clr;
		logic [PT_W-1:0] term_idx;
		logic            w_init;
		logic            w_mul;
		logic            w_sel_s;
		logic            prod_en;
		logic            acc_en;
		logic            div_init;
		logic            div_step;
		logic            out_load;
		logic            samp_inc;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count_eff;
		logic [PT_W-1:0]  degree;
		logic             last;
		logic             out_busy;
	} status_t;

endpackage

// ----- src/bezier_curve_sampler_core.sv -----
// Top level of the Bezier curve sampler: controller and datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    point_x, point_y
//   out      output     out_valid / out_ready  curve_x, curve_y, sample_index, last_sample
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A point that does not complete a curve is stored and counted. A completing point first
// forms steps^n in the ST_DEN state, then each sample runs the shared weight multiplier
// and accumulator over every term, then the divider and output load. The output register
// lets the next sample compute while one waits; a stall holds the engine once
// the next is ready. Reset clears the controller and point count and restores
// the default configuration.
module bezier_curve_sampler_core import bcs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [OUT_W-1:0]   curve_x,
	output logic signed [OUT_W-1:0]   curve_y,
	output logic [IDX_W-1:0]          sample_index,
	output logic                      last_sample,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	cmd_t cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	bcs_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.curve_x(curve_x),
		.curve_y(curve_y),
		.sample_index(sample_index),
		.last_sample(last_sample)
	);

endmodule

// ----- src/bcs_ctrl.sv -----
// Controller state machine that sequences collection, weights, sums and division.
module bcs_ctrl import bcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic [PT_W-1:0] pr_q, pr_d;
	logic [PT_W-1:0] i_q, i_d;
	logic [PT_W-1:0] j_q, j_d;
	logic [4:0] k_q, k_d;
	logic [CNT_W-1:0] pr_next;

	assign pr_next = CNT_W'(pr_q) + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			pr_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			pr_q <= pr_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pr_d = pr_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cmd = '0;
		cmd.store_idx = pr_q;
		cmd.term_idx = i_q;
		cmd.w_sel_s = (j_q < i_q);
		in_ready = 1'b0;
		case (state_q)
			ST_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store_we = 1'b1;
					if (pr_next >= status.count_eff) begin
						pr_d = '0;
						j_d = '0;
						cmd.curve_start = 1'b1;
						state_d = ST_DEN;
					end else begin
						pr_d = pr_next[PT_W-1:0];
					end
				end
			end
			ST_DEN: begin
				cmd.den_mul = 1'b1;
				if (j_q == status.degree - PT_W'(1)) begin
					state_d = ST_SAMPLE;
				end else begin
					j_d = j_q + PT_W'(1);
				end
			end
			ST_SAMPLE: begin
				cmd.acc_clr = 1'b1;
				i_d = '0;
				state_d = ST_TERM;
			end
			ST_TERM: begin
				cmd.w_init = 1'b1;
				j_d = '0;
				state_d = ST_WMUL;
			end
			ST_WMUL: begin
				cmd.w_mul = 1'b1;
				if (j_q == status.degree - PT_W'(1)) begin
					state_d = ST_PROD;
				end else begin
					j_d = j_q + PT_W'(1);
				end
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				if (i_q == status.degree) begin
					state_d = ST_DIV_INIT;
				end else begin
					i_d = i_q + PT_W'(1);
					state_d = ST_TERM;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				k_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (k_q == 5'(OUT_W - 1)) begin
					state_d = ST_EMIT;
				end else begin
					k_d = k_q + 5'd1;
				end
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					if (status.last) begin
						state_d = ST_COLLECT;
					end else begin
						cmd.samp_inc = 1'b1;
						state_d = ST_SAMPLE;
					end
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

endmodule

// ----- src/bcs_datapath.sv -----
// Datapath: point store, configuration, weight multiplier, sums, divider and output register.
module bcs_datapath import bcs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  logic                         cfg_valid,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [COORD_W-1:0]    point_x,
	input  logic signed [COORD_W-1:0]    point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [OUT_W-1:0]      curve_x,
	output logic signed [OUT_W-1:0]      curve_y,
	output logic [IDX_W-1:0]             sample_index,
	output logic                         last_sample
);

	logic [2*COORD_W-1:0] store_q [MAX_CONTROL];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] steps_q;
	logic [CNT_W-1:0] count_eff;
	logic [IDX_W-1:0] steps_eff;
	logic [PT_W-1:0] n_q;
	logic [IDX_W-1:0] st_q;
	logic [IDX_W-1:0] s_q;
	logic [DEN_W-1:0] den_q;
	logic [WPART_W-1:0] w_q;
	logic [IDX_W-1:0] w_fac;
	logic signed [ACC_W-1:0] prod_x_q, prod_y_q, acc_x_q, acc_y_q;
	logic signed [ACC_W:0] mul_x, mul_y;
	logic [ACC_W-1:0] mag_x, mag_y;
	logic [REM_W-1:0] rem_x_q, rem_y_q, dv_q;
	logic [OUT_W-1:0] q_x_q, q_y_q;
	logic neg_x_q, neg_y_q;
	logic out_valid_q;
	logic signed [OUT_W-1:0] curve_x_q, curve_y_q;
	logic [IDX_W-1:0] index_q;
	logic last_q;

	always_comb begin
		if (count_q < CNT_W'(2)) begin
			count_eff = CNT_W'(2);
		end else if (count_q > CNT_W'(MAX_CONTROL)) begin
			count_eff = CNT_W'(MAX_CONTROL);
		end else begin
			count_eff = count_q;
		end
		steps_eff = (steps_q == '0) ? IDX_W'(1) : steps_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(4);
			steps_q <= IDX_W'(15);
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CONTROL_COUNT) begin
				count_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == CFG_CURVE_STEPS) begin
				steps_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_we) begin
			store_q[cmd.store_idx] <= {point_y, point_x};
		end
	end

	assign w_fac = cmd.w_sel_s ? s_q : (st_q - s_q);
	assign mul_x = $signed({1'b0, w_q[DEN_W-1:0]})
		* $signed(store_q[cmd.term_idx][COORD_W-1:0]);
	assign mul_y = $signed({1'b0, w_q[DEN_W-1:0]})
		* $signed(store_q[cmd.term_idx][2*COORD_W-1:COORD_W]);
	assign mag_x = acc_x_q[ACC_W-1] ? ACC_W'(-acc_x_q) : ACC_W'(acc_x_q);
	assign mag_y = acc_y_q[ACC_W-1] ? ACC_W'(-acc_y_q) : ACC_W'(acc_y_q);

	always_ff @(posedge clk) begin
		if (cmd.curve_start) begin
			n_q <= PT_W'(count_eff - CNT_W'(1));
			st_q <= steps_eff;
			s_q <= '0;
			den_q <= DEN_W'(1);
		end else begin
			if (cmd.den_mul) den_q <= DEN_W'(den_q * st_q);
			if (cmd.samp_inc) s_q <= s_q + IDX_W'(1);
		end
		if (cmd.w_init) begin
			w_q <= WPART_W'(BINOM[n_q][cmd.term_idx]);
		end else if (cmd.w_mul) begin
			w_q <= WPART_W'(w_q * w_fac);
		end
		if (cmd.prod_en) begin
			prod_x_q <= mul_x[ACC_W-1:0];
			prod_y_q <= mul_y[ACC_W-1:0];
		end
		if (cmd.acc_clr) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (cmd.acc_en) begin
			acc_x_q <= acc_x_q + prod_x_q;
			acc_y_q <= acc_y_q + prod_y_q;
		end
		// Rounded division: long division one quotient bit a cycle, top bit first.
		if (cmd.div_init) begin
			neg_x_q <= acc_x_q[ACC_W-1];
			neg_y_q <= acc_y_q[ACC_W-1];
			rem_x_q <= REM_W'({mag_x, {FRAC_W{1'b0}}}) + REM_W'(den_q >> 1);
			rem_y_q <= REM_W'({mag_y, {FRAC_W{1'b0}}}) + REM_W'(den_q >> 1);
			dv_q <= REM_W'(den_q) << (OUT_W - 1);
			q_x_q <= '0;
			q_y_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_x_q >= dv_q) begin
				rem_x_q <= rem_x_q - dv_q;
				q_x_q <= {q_x_q[OUT_W-2:0], 1'b1};
			end else begin
				q_x_q <= {q_x_q[OUT_W-2:0], 1'b0};
			end
			if (rem_y_q >= dv_q) begin
				rem_y_q <= rem_y_q - dv_q;
				q_y_q <= {q_y_q[OUT_W-2:0], 1'b1};
			end else begin
				q_y_q <= {q_y_q[OUT_W-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.out_load) begin
			curve_x_q <= neg_x_q ? $signed(-q_x_q) : $signed(q_x_q);
			curve_y_q <= neg_y_q ? $signed(-q_y_q) : $signed(q_y_q);
			index_q <= s_q;
			last_q <= (s_q == st_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.count_eff = count_eff;
	assign status.degree = n_q;
	assign status.last = (s_q == st_q);
	assign status.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign curve_x = curve_x_q;
	assign curve_y = curve_y_q;
	assign sample_index = index_q;
	assign last_sample = last_q;

endmodule

// ----- src/bcs_checker.sv -----
// Port-level checks of the Bezier curve sampler and their binding.
module bcs_checker import bcs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [OUT_W-1:0]   curve_x,
	input logic [IDX_W-1:0]          sample_index,
	input logic                      last_sample
);

	// A pending result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(sample_index))
		else $error("output changed while stalled");

	// The final sample never has index zero, since a curve has at least one interval.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_sample |-> sample_index != '0)
		else $error("last sample at index zero");

	// Mid-curve, the engine does not take new points.
	a_no_point_mid_curve: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_sample |=> !in_ready)
		else $error("point accepted during a curve");

	// No point is taken while a non-final sample waits.
	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_sample |-> !in_ready)
		else $error("input ready with a curve in progress");

endmodule

bind bezier_curve_sampler_core bcs_checker u_bcs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.curve_x(curve_x),
	.sample_index(sample_index),
	.last_sample(last_sample)
);
